/* sv/wsd_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; used by every module of the block.
package wsd_pkg;

   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_FIRST    = 2'd1;
   localparam logic [1:0] ERR_HIGH_LEN = 2'd2;
   localparam logic [1:0] ERR_TOO_LONG = 2'd3;

   localparam logic [3:0] OP_CONT   = 4'h0;
   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_CLOSE  = 4'h8;
   localparam logic [3:0] OP_PING   = 4'h9;
   localparam logic [3:0] OP_PONG   = 4'hA;

   localparam logic [2:0] TYPE_CLOSE = 3'd3;
   localparam logic [2:0] TYPE_PING  = 3'd4;
   localparam logic [2:0] TYPE_PONG  = 3'd5;

   localparam logic [6:0] LEN_CODE_16 = 7'd126;
   localparam logic [6:0] LEN_CODE_64 = 7'd127;
   localparam logic [3:0] EXT_BYTES_16 = 4'd2;
   localparam logic [3:0] EXT_BYTES_64 = 4'd8;
   localparam logic [3:0] HIGH_BYTES_LIMIT = 4'd4;
   localparam logic [3:0] KEY_BYTES = 4'd4;

   localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd65536;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [4:0] {
      PH_FIRST   = 5'b00001,
      PH_SECOND  = 5'b00010,
      PH_EXTLEN  = 5'b00100,
      PH_KEY     = 5'b01000,
      PH_PAYLOAD = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  frame_type;
      logic        masked;
      logic [31:0] payload_length;
      logic [7:0]  data;
      logic [7:0]  key;
      logic        last;
      logic [1:0]  error_code;
   } cmd_type;

endpackage

/* sv/wsd_front.sv */
`timescale 1ns / 1ps
// Header parser of the deframer: tracks frame phase, length and mask key,
// and turns each stream byte into zero or one command. Uses wsd_pkg.
module wsd_front #(
   parameter int LENGTH_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic [7:0]        stream_byte,
   input  logic              csr_wr_en,
   input  logic [31:0]       csr_wr_data,
   output logic              push,
   output wsd_pkg::cmd_type  cmd
);

   wsd_pkg::phase_type     phase_ff, phase_in;
   logic [3:0]             cnt_ff, cnt_in;
   logic [2:0]             type_ff, type_in;
   logic                   mask_ff, mask_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic [31:0]            key_ff, key_in;
   logic [1:0]             kidx_ff, kidx_in;
   logic [LENGTH_BITS-1:0] left_ff, left_in;
   logic [31:0]            max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= wsd_pkg::PH_FIRST;
         cnt_ff   <= '0;
         type_ff  <= '0;
         mask_ff  <= 1'b0;
         len_ff   <= '0;
         key_ff   <= '0;
         kidx_ff  <= '0;
         left_ff  <= '0;
         max_ff   <= wsd_pkg::MAX_PAYLOAD_RESET;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         type_ff  <= type_in;
         mask_ff  <= mask_in;
         len_ff   <= len_in;
         key_ff   <= key_in;
         kidx_ff  <= kidx_in;
         left_ff  <= left_in;
         if (csr_wr_en) begin
            max_ff <= csr_wr_data;
         end
      end
   end

   always_comb begin
      logic                   len_done;
      logic                   emit;
      logic                   fail;
      logic [1:0]             fail_code;
      logic [LENGTH_BITS-1:0] hdr_len;
      logic [3:0]             cnt_dec;
      logic [7:0]             kb;
      logic [LENGTH_BITS-1:0] left_dec;

      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      type_in   = type_ff;
      mask_in   = mask_ff;
      len_in    = len_ff;
      key_in    = key_ff;
      kidx_in   = kidx_ff;
      left_in   = left_ff;
      push      = 1'b0;
      cmd       = '0;
      len_done  = 1'b0;
      emit      = 1'b0;
      fail      = 1'b0;
      fail_code = wsd_pkg::ERR_NONE;
      hdr_len   = len_ff;
      cnt_dec   = (cnt_ff != 4'd0) ? cnt_ff - 4'd1 : 4'd0;
      kb        = 8'd0;
      left_dec  = (left_ff != '0) ? left_ff - 1'b1 : '0;

      if (take) begin
         unique case (phase_ff)
            wsd_pkg::PH_SECOND: begin
               mask_in = stream_byte[7];
               len_in  = '0;
               if (stream_byte[6:0] == wsd_pkg::LEN_CODE_16) begin
                  phase_in = wsd_pkg::PH_EXTLEN;
                  cnt_in   = wsd_pkg::EXT_BYTES_16;
               end else if (stream_byte[6:0] == wsd_pkg::LEN_CODE_64) begin
                  phase_in = wsd_pkg::PH_EXTLEN;
                  cnt_in   = wsd_pkg::EXT_BYTES_64;
               end else begin
                  len_in   = LENGTH_BITS'(stream_byte[6:0]);
                  hdr_len  = LENGTH_BITS'(stream_byte[6:0]);
                  len_done = 1'b1;
               end
            end
            wsd_pkg::PH_EXTLEN: begin
               if (cnt_ff > wsd_pkg::HIGH_BYTES_LIMIT && stream_byte != 8'd0) begin
                  fail      = 1'b1;
                  fail_code = wsd_pkg::ERR_HIGH_LEN;
               end else if (len_ff[LENGTH_BITS-1 -: 8] != 8'd0) begin
                  fail      = 1'b1;
                  fail_code = wsd_pkg::ERR_TOO_LONG;
               end else begin
                  len_in  = {len_ff[LENGTH_BITS-9:0], stream_byte};
                  hdr_len = {len_ff[LENGTH_BITS-9:0], stream_byte};
                  cnt_in  = cnt_dec;
                  if (cnt_dec == 4'd0) begin
                     len_done = 1'b1;
                  end
               end
            end
            wsd_pkg::PH_KEY: begin
               key_in = {key_ff[23:0], stream_byte};
               cnt_in = cnt_dec;
               if (cnt_dec == 4'd0) begin
                  emit = 1'b1;
               end
            end
            wsd_pkg::PH_PAYLOAD: begin
               if (mask_ff) begin
                  case (kidx_ff)
                     2'd0:    kb = key_ff[31:24];
                     2'd1:    kb = key_ff[23:16];
                     2'd2:    kb = key_ff[15:8];
                     default: kb = key_ff[7:0];
                  endcase
               end
               kidx_in = kidx_ff + 2'd1;
               left_in = left_dec;
               if (left_dec == '0) begin
                  phase_in = wsd_pkg::PH_FIRST;
               end
               push                = 1'b1;
               cmd.kind            = wsd_pkg::KIND_PAYLOAD;
               cmd.frame_type      = type_ff;
               cmd.masked          = mask_ff;
               cmd.payload_length  = 32'(len_ff);
               cmd.data            = stream_byte;
               cmd.key             = kb;
               cmd.last            = (left_dec == '0);
            end
            default: begin
               if (!stream_byte[7]) begin
                  fail      = 1'b1;
                  fail_code = wsd_pkg::ERR_FIRST;
               end else begin
                  unique case (stream_byte[3:0]) inside
                     wsd_pkg::OP_CONT,
                     wsd_pkg::OP_TEXT,
                     wsd_pkg::OP_BINARY: type_in = stream_byte[2:0];
                     wsd_pkg::OP_CLOSE:  type_in = wsd_pkg::TYPE_CLOSE;
                     wsd_pkg::OP_PING:   type_in = wsd_pkg::TYPE_PING;
                     wsd_pkg::OP_PONG:   type_in = wsd_pkg::TYPE_PONG;
                     default: begin
                        fail      = 1'b1;
                        fail_code = wsd_pkg::ERR_FIRST;
                     end
                  endcase
                  if (!fail) begin
                     mask_in  = 1'b0;
                     len_in   = '0;
                     key_in   = '0;
                     kidx_in  = '0;
                     left_in  = '0;
                     cnt_in   = '0;
                     phase_in = wsd_pkg::PH_SECOND;
                  end
               end
            end
         endcase

         if (len_done) begin
            if (32'(hdr_len) > max_ff) begin
               fail      = 1'b1;
               fail_code = wsd_pkg::ERR_TOO_LONG;
            end else if (mask_in) begin
               phase_in = wsd_pkg::PH_KEY;
               cnt_in   = wsd_pkg::KEY_BYTES;
               key_in   = '0;
            end else begin
               key_in = '0;
               emit   = 1'b1;
            end
         end

         if (emit) begin
            push               = 1'b1;
            cmd.kind           = wsd_pkg::KIND_HEADER;
            cmd.frame_type     = type_ff;
            cmd.masked         = mask_in;
            cmd.payload_length = 32'(hdr_len);
            cmd.last           = (hdr_len == '0);
            kidx_in            = '0;
            left_in            = hdr_len;
            phase_in           = (hdr_len == '0) ? wsd_pkg::PH_FIRST : wsd_pkg::PH_PAYLOAD;
         end

         if (fail) begin
            phase_in       = wsd_pkg::PH_FIRST;
            cnt_in         = '0;
            left_in        = '0;
            kidx_in        = '0;
            type_in        = type_ff;
            push           = 1'b1;
            cmd            = '0;
            cmd.kind       = wsd_pkg::KIND_ERROR;
            cmd.last       = 1'b1;
            cmd.error_code = fail_code;
         end
      end
   end

endmodule

/* sv/wsd_queue.sv */
`timescale 1ns / 1ps
// Two-entry command queue between the header parser and the result stage.
// Uses wsd_pkg for the command type and depth.
module wsd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  wsd_pkg::cmd_type  push_cmd,
   input  logic              pop,
   output wsd_pkg::cmd_type  pop_cmd,
   output logic              full,
   output logic              empty
);

   localparam int PTR_BITS = $clog2(wsd_pkg::QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(wsd_pkg::QUEUE_DEPTH + 1);

   wsd_pkg::cmd_type    entries_ff [wsd_pkg::QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   assign full    = (count_ff == CNT_BITS'(wsd_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_cmd = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(wsd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(wsd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* sv/wsd_back.sv */
`timescale 1ns / 1ps
// Result stage: unmasks payload bytes and holds each result beat until taken.
// Uses wsd_pkg for the command type.
module wsd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  wsd_pkg::cmd_type  q_cmd,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_kind,
   output logic [2:0]        rsp_frame_type,
   output logic              rsp_masked,
   output logic [31:0]       rsp_payload_length,
   output logic [7:0]        rsp_payload_byte,
   output logic              rsp_last,
   output logic [1:0]        rsp_error_code
);

   logic        valid_ff, valid_in;
   logic [1:0]  kind_ff;
   logic [2:0]  type_ff;
   logic        masked_ff;
   logic [31:0] len_ff;
   logic [7:0]  byte_ff;
   logic        last_ff;
   logic [1:0]  err_ff;

   assign q_pop    = !q_empty && (!valid_ff || !rsp_stall);
   assign valid_in = q_pop || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         kind_ff   <= q_cmd.kind;
         type_ff   <= q_cmd.frame_type;
         masked_ff <= q_cmd.masked;
         len_ff    <= q_cmd.payload_length;
         byte_ff   <= q_cmd.data ^ q_cmd.key;
         last_ff   <= q_cmd.last;
         err_ff    <= q_cmd.error_code;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_frame_type     = type_ff;
   assign rsp_masked         = masked_ff;
   assign rsp_payload_length = len_ff;
   assign rsp_payload_byte   = byte_ff;
   assign rsp_last           = last_ff;
   assign rsp_error_code     = err_ff;

endmodule

/* sv/websocket_frame_deframer.sv */
`timescale 1ns / 1ps
// WebSocket frame deframer top level: parser, command queue and result stage.
// Depends on wsd_pkg, wsd_front, wsd_queue and wsd_back.

// Takes one stream byte per cycle while req_stall is low and gives at most
// one result beat per byte: a header beat when the header is complete, one
// beat per unmasked payload byte, or an error beat. The parser updates its
// state once for every accepted byte, so the sustained rate is one byte per
// clock while req_stall is low; the parser writes each command into the
// two-entry queue when its byte is accepted, and the result stage loads it
// from the queue into the rsp_ output register. req_stall rises only when
// the queue is full because the result side is stalling, and stays high for
// the cycle in which a full queue hands one entry on. csr_wr_data sets the
// largest accepted payload length (65536 after reset); write it while idle.
// LENGTH_BITS (16 to 32) sets the width of the length and byte counters;
// longer lengths are flagged as too long.
module websocket_frame_deframer #(
   parameter int LENGTH_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_stream_byte,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [2:0]  rsp_frame_type,
   output logic        rsp_masked,
   output logic [31:0] rsp_payload_length,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_last,
   output logic [1:0]  rsp_error_code
);

   logic             take;
   logic             push;
   wsd_pkg::cmd_type push_cmd;
   wsd_pkg::cmd_type pop_cmd;
   logic             pop;
   logic             q_full;
   logic             q_empty;

   assign req_stall = q_full;
   assign take      = req_valid && !req_stall;

   wsd_front #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .stream_byte (req_stream_byte),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .push        (push),
      .cmd         (push_cmd)
   );

   wsd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .full     (q_full),
      .empty    (q_empty)
   );

   wsd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_empty            (q_empty),
      .q_cmd              (pop_cmd),
      .q_pop              (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_frame_type     (rsp_frame_type),
      .rsp_masked         (rsp_masked),
      .rsp_payload_length (rsp_payload_length),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_last           (rsp_last),
      .rsp_error_code     (rsp_error_code)
   );

   a_error_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == wsd_pkg::KIND_ERROR)
         |-> (rsp_last && rsp_error_code != wsd_pkg::ERR_NONE))
      else $error("error beat without last or code");

   a_ok_no_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != wsd_pkg::KIND_ERROR)
         |-> (rsp_error_code == wsd_pkg::ERR_NONE))
      else $error("header or payload beat carries an error code");

   a_empty_hdr_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == wsd_pkg::KIND_HEADER && rsp_payload_length == 32'd0)
         |-> rsp_last)
      else $error("zero-length header not marked last");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !push)
      else $error("command pushed into full queue");

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for websocket_frame_deframer: streams framed bytes, predicts every
// header, payload and error beat and compares them in order. Depends on wsd_pkg and the RTL.

typedef struct packed {
   logic [1:0]  kind;
   logic [2:0]  frame_type;
   logic        masked;
   logic [31:0] length;
   logic [7:0]  data;
   logic        last;
   logic [1:0]  code;
} deframe_beat_type;

class deframe_board;
   logic [31:0]        max_len;
   wsd_pkg::phase_type phase;
   logic [3:0]         ext_count;
   logic [2:0]         held_type;
   logic               held_mask;
   logic [31:0]        held_len;
   logic [31:0]        key_word;
   logic [1:0]         key_pos;
   logic [31:0]        bytes_left;
   deframe_beat_type   due_beats[$];
   int                 errors;

   function new();
      max_len    = wsd_pkg::MAX_PAYLOAD_RESET;
      phase      = wsd_pkg::PH_FIRST;
      ext_count  = '0;
      held_type  = '0;
      held_mask  = 1'b0;
      held_len   = '0;
      key_word   = '0;
      key_pos    = '0;
      bytes_left = '0;
      errors     = 0;
   endfunction

   function void push_beat(logic [1:0] kind, logic [2:0] ftype, logic mask, logic [31:0] len,
                           logic [7:0] data, logic last, logic [1:0] code);
      deframe_beat_type beat;
      beat = '{kind, ftype, mask, len, data, last, code};
      due_beats.push_back(beat);
   endfunction

   function void reject(logic [1:0] code);
      phase      = wsd_pkg::PH_FIRST;
      ext_count  = '0;
      bytes_left = '0;
      key_pos    = '0;
      push_beat(wsd_pkg::KIND_ERROR, 3'd0, 1'b0, 32'd0, 8'd0, 1'b1, code);
   endfunction

   function void open_payload();
      logic last;
      last = (held_len == 0);
      push_beat(wsd_pkg::KIND_HEADER, held_type, held_mask, held_len, 8'd0, last,
                wsd_pkg::ERR_NONE);
      key_pos    = '0;
      bytes_left = held_len;
      phase      = last ? wsd_pkg::PH_FIRST : wsd_pkg::PH_PAYLOAD;
   endfunction

   function void length_complete();
      key_word = '0;
      if (held_len > max_len) begin
         reject(wsd_pkg::ERR_TOO_LONG);
      end else if (held_mask) begin
         phase     = wsd_pkg::PH_KEY;
         ext_count = wsd_pkg::KEY_BYTES;
      end else begin
         open_payload();
      end
   endfunction

   function void note_byte(logic [7:0] b);
      logic [39:0] wide;
      logic [7:0]  pad;
      logic        last;
      logic        known;
      case (phase)
         wsd_pkg::PH_SECOND: begin
            held_mask = b[7];
            held_len  = '0;
            if (b[6:0] == wsd_pkg::LEN_CODE_16) begin
               phase     = wsd_pkg::PH_EXTLEN;
               ext_count = wsd_pkg::EXT_BYTES_16;
            end else if (b[6:0] == wsd_pkg::LEN_CODE_64) begin
               phase     = wsd_pkg::PH_EXTLEN;
               ext_count = wsd_pkg::EXT_BYTES_64;
            end else begin
               held_len = {25'd0, b[6:0]};
               length_complete();
            end
         end
         wsd_pkg::PH_EXTLEN: begin
            wide = {held_len, b};
            if (ext_count > wsd_pkg::HIGH_BYTES_LIMIT && b != 8'd0) begin
               reject(wsd_pkg::ERR_HIGH_LEN);
            end else if (wide[39:32] != 8'd0) begin
               reject(wsd_pkg::ERR_TOO_LONG);
            end else begin
               held_len  = wide[31:0];
               ext_count = ext_count - 4'd1;
               if (ext_count == 4'd0) length_complete();
            end
         end
         wsd_pkg::PH_KEY: begin
            key_word  = {key_word[23:0], b};
            ext_count = ext_count - 4'd1;
            if (ext_count == 4'd0) open_payload();
         end
         wsd_pkg::PH_PAYLOAD: begin
            pad        = held_mask ? key_word[8 * (3 - key_pos) +: 8] : 8'd0;
            key_pos    = key_pos + 2'd1;
            bytes_left = bytes_left - 32'd1;
            last       = (bytes_left == 0);
            if (last) phase = wsd_pkg::PH_FIRST;
            push_beat(wsd_pkg::KIND_PAYLOAD, held_type, held_mask, held_len, b ^ pad, last,
                      wsd_pkg::ERR_NONE);
         end
         default: begin
            known = 1'b1;
            case (b[3:0]) inside
               wsd_pkg::OP_CONT, wsd_pkg::OP_TEXT, wsd_pkg::OP_BINARY: held_type = b[2:0];
               wsd_pkg::OP_CLOSE: held_type = wsd_pkg::TYPE_CLOSE;
               wsd_pkg::OP_PING:  held_type = wsd_pkg::TYPE_PING;
               wsd_pkg::OP_PONG:  held_type = wsd_pkg::TYPE_PONG;
               default:           known = 1'b0;
            endcase
            if (!b[7] || !known) begin
               reject(wsd_pkg::ERR_FIRST);
            end else begin
               held_mask  = 1'b0;
               held_len   = '0;
               key_word   = '0;
               key_pos    = '0;
               bytes_left = '0;
               ext_count  = '0;
               phase      = wsd_pkg::PH_SECOND;
            end
         end
      endcase
   endfunction

   task report(string what, logic [31:0] want, logic [31:0] got);
      errors++;
      if (errors <= 100) $display("%0t mismatch %s: expected %0h got %0h", $time, what, want, got);
   endtask

   task check_beat(deframe_beat_type got);
      deframe_beat_type want;
      if (due_beats.size() == 0) begin
         report("unexpected beat, kind", 32'd0, {30'd0, got.kind});
      end else begin
         want = due_beats.pop_front();
         if (got.kind !== want.kind) report("kind", 32'(want.kind), 32'(got.kind));
         if (got.frame_type !== want.frame_type)
            report("frame_type", 32'(want.frame_type), 32'(got.frame_type));
         if (got.masked !== want.masked) report("masked", 32'(want.masked), 32'(got.masked));
         if (got.length !== want.length) report("payload_length", want.length, got.length);
         if (got.data !== want.data) report("payload_byte", 32'(want.data), 32'(got.data));
         if (got.last !== want.last) report("last", 32'(want.last), 32'(got.last));
         if (got.code !== want.code) report("error_code", 32'(want.code), 32'(got.code));
      end
   endtask
endclass

module tb;
   localparam logic [3:0] BAD_OP = 4'hF;

   localparam logic [7:0] OPENING_STREAM [35] = '{
      {1'b1, 3'b000, wsd_pkg::OP_CONT}, {1'b1, 7'd5}, 8'hA5, 8'h5A, 8'h0F, 8'hF0,
      8'h11, 8'h22, 8'h33, 8'h44, 8'h55,
      {1'b1, 3'b111, wsd_pkg::OP_TEXT}, 8'h00,
      {1'b1, 3'b000, wsd_pkg::OP_BINARY}, {1'b0, wsd_pkg::LEN_CODE_16}, 8'h00, 8'h01, 8'hFF,
      {1'b1, 3'b000, wsd_pkg::OP_CLOSE}, {1'b0, wsd_pkg::LEN_CODE_64},
      8'h00, 8'h00, 8'h00, 8'h00,
      8'hFF, 8'hFF, 8'hFF, 8'hFF,
      {1'b1, 3'b000, wsd_pkg::OP_PING}, {1'b0, wsd_pkg::LEN_CODE_64}, 8'h80,
      {1'b0, 3'b000, wsd_pkg::OP_PONG},
      {1'b1, 3'b000, wsd_pkg::OP_PONG}, 8'h00,
      {1'b1, 3'b000, BAD_OP}
   };
   localparam logic [31:0] MAX_SETTINGS [6] = '{
      32'hFFFF_FFFF, 32'd0, 32'd20, 32'd126, 32'd300, wsd_pkg::MAX_PAYLOAD_RESET
   };
   localparam int IDLE_SETTINGS [6]  = '{0, 78, 0, 27, 0, 27};
   localparam int STALL_SETTINGS [6] = '{0, 0, 78, 27, 0, 27};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_stream_byte = 8'd0;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = 32'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [2:0]  rsp_frame_type;
   logic        rsp_masked;
   logic [31:0] rsp_payload_length;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_last;
   logic [1:0]  rsp_error_code;

   int           idle_pct = 0;
   int           stall_pct = 0;
   int           sent_beats = 0;
   deframe_board board = new();

   websocket_frame_deframer u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_stream_byte    (req_stream_byte),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_frame_type     (rsp_frame_type),
      .rsp_masked         (rsp_masked),
      .rsp_payload_length (rsp_payload_length),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_last           (rsp_last),
      .rsp_error_code     (rsp_error_code)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin : watch_rsp
      deframe_beat_type seen;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.kind       = rsp_kind;
         seen.frame_type = rsp_frame_type;
         seen.masked     = rsp_masked;
         seen.length     = rsp_payload_length;
         seen.data       = rsp_payload_byte;
         seen.last       = rsp_last;
         seen.code       = rsp_error_code;
         board.check_beat(seen);
      end
   end

   task automatic send_byte(input logic [7:0] value);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_stream_byte <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_byte(value);
      sent_beats++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.due_beats.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_max(input logic [31:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.max_len = value;
   endtask

   function automatic logic [7:0] random_first_byte();
      logic [3:0] op;
      case ($urandom_range(5))
         0:       op = wsd_pkg::OP_CONT;
         1:       op = wsd_pkg::OP_TEXT;
         2:       op = wsd_pkg::OP_BINARY;
         3:       op = wsd_pkg::OP_CLOSE;
         4:       op = wsd_pkg::OP_PING;
         default: op = wsd_pkg::OP_PONG;
      endcase
      return {1'b1, 3'($urandom_range(7)), op};
   endfunction

   // finish whatever frame the parser is inside so the next frame starts aligned
   task automatic resync();
      while (board.phase != wsd_pkg::PH_FIRST) begin
         if (board.phase == wsd_pkg::PH_SECOND || board.phase == wsd_pkg::PH_EXTLEN)
            send_byte(8'h00);
         else send_byte(8'($urandom_range(255)));
      end
   endtask

   task automatic send_frame(input bit truncate);
      logic [7:0]  bytes_q[$];
      logic [31:0] len;
      logic [32:0] over;
      logic        masked;
      int          form;
      int          head_len;
      int          cut;
      bytes_q.push_back(random_first_byte());
      masked = 1'($urandom_range(1));
      form   = $urandom_range(99);
      if (form < 75) begin
         len = ($urandom_range(3) == 0) ? $urandom_range(125) : $urandom_range(12);
      end else begin
         case ($urandom_range(3))
            0: begin
               over = {1'b0, board.max_len} + 33'd1 + 33'($urandom_range(999));
               len  = over[32] ? 32'hFFFF_FFFF : over[31:0];
            end
            1:       len = $urandom();
            default: len = $urandom_range(300);
         endcase
         if (form < 90) len[31:16] = '0;
         if (len <= board.max_len && len > 300) len = len % 301;
      end
      if (form < 75) begin
         bytes_q.push_back({masked, len[6:0]});
      end else if (form < 90) begin
         bytes_q.push_back({masked, wsd_pkg::LEN_CODE_16});
         bytes_q.push_back(len[15:8]);
         bytes_q.push_back(len[7:0]);
      end else begin
         bytes_q.push_back({masked, wsd_pkg::LEN_CODE_64});
         repeat (4) bytes_q.push_back(8'h00);
         bytes_q.push_back(len[31:24]);
         bytes_q.push_back(len[23:16]);
         bytes_q.push_back(len[15:8]);
         bytes_q.push_back(len[7:0]);
      end
      head_len = bytes_q.size();
      if (len <= board.max_len) begin
         if (masked) repeat (4) bytes_q.push_back(8'($urandom_range(255)));
         repeat (len) bytes_q.push_back(8'($urandom_range(255)));
      end
      cut = bytes_q.size();
      if (truncate && cut > head_len) cut = $urandom_range(head_len, cut - 1);
      for (int i = 0; i < cut; i++) send_byte(bytes_q[i]);
   endtask

   task automatic send_broken();
      logic [3:0] op;
      int         zeros;
      case ($urandom_range(2))
         0: send_byte({1'b0, 7'($urandom_range(127))});
         1: begin
            op = 4'($urandom_range(9));
            op = (op < 4'd5) ? op + 4'd3 : op + 4'd6;
            send_byte({1'b1, 3'($urandom_range(7)), op});
         end
         default: begin
            send_byte(random_first_byte());
            send_byte({1'($urandom_range(1)), wsd_pkg::LEN_CODE_64});
            zeros = $urandom_range(3);
            repeat (zeros) send_byte(8'h00);
            send_byte(8'($urandom_range(1, 255)));
         end
      endcase
   endtask

   task automatic send_noise();
      int         count;
      logic [7:0] value;
      count = $urandom_range(1, 6);
      repeat (count) begin
         value = 8'($urandom_range(255));
         // keep stray headers short when the limit would let a huge payload through
         if (board.phase == wsd_pkg::PH_SECOND && board.max_len > 300 && value[6:1] == 6'h3F)
            value[1] = 1'b0;
         send_byte(value);
      end
   endtask

   task automatic run_random(input int target);
      int start;
      int pick;
      start = sent_beats;
      while (sent_beats - start < target) begin
         resync();
         pick = $urandom_range(99);
         if (pick < 75) send_frame(1'b0);
         else if (pick < 85) send_broken();
         else if (pick < 93) send_noise();
         else send_frame(1'b1);
      end
      resync();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (OPENING_STREAM[i]) send_byte(OPENING_STREAM[i]);
      drain();
      for (int p = 0; p < 6; p++) begin
         write_max(MAX_SETTINGS[p]);
         idle_pct  = IDLE_SETTINGS[p];
         stall_pct = STALL_SETTINGS[p];
         run_random(290);
         drain();
      end
      if (board.errors == 0 && board.due_beats.size() == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end
endmodule
